>>> hdl/hsvrgb_pkg.sv
// Package for the HSV to RGB converter: shared widths, lane indexes and the hue sector codes.
// No dependencies; every other file of the converter imports it.
`default_nettype none

package hsvrgb_pkg;

  localparam int unsigned HUE_W = 16;
  localparam int unsigned RAMP_W = 10;

  localparam int unsigned LANE_R = 0;
  localparam int unsigned LANE_G = 1;
  localparam int unsigned LANE_B = 2;
  localparam int unsigned LANE_A = 3;

  localparam int unsigned NUM_COLOUR_LANES = 3;
  localparam int unsigned NUM_LANES = 4;

  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

endpackage

`default_nettype wire

>>> hdl/hsvrgb_hsva_if.sv
// Input channel of the converter: valid/ready handshake with an HSVA colour as payload.
// Depends on hsvrgb_pkg for the hue width.
`default_nettype none

interface hsvrgb_hsva_if import hsvrgb_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8
);

  logic                          valid;
  logic                          ready;
  logic signed [HUE_W-1:0]       hue;
  logic [COMPONENT_BITS-1:0]     saturation;
  logic [COMPONENT_BITS-1:0]     brightness;
  logic [COMPONENT_BITS-1:0]     alpha_in;

  modport source (output valid, output hue, output saturation, output brightness,
                  output alpha_in, input ready);
  modport sink (input valid, input hue, input saturation, input brightness,
                input alpha_in, output ready);

endinterface

`default_nettype wire

>>> hdl/hsvrgb_rgba_if.sv
// Output channel of the converter: valid/ready handshake with an RGBA colour as payload.
// Depends on hsvrgb_pkg only through the shared import convention.
`default_nettype none

interface hsvrgb_rgba_if import hsvrgb_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8
);

  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red;
  logic [COMPONENT_BITS-1:0] green;
  logic [COMPONENT_BITS-1:0] blue;
  logic [COMPONENT_BITS-1:0] alpha_out;

  modport source (output valid, output red, output green, output blue, output alpha_out,
                  input ready);
  modport sink (input valid, input red, input green, input blue, input alpha_out,
                output ready);

endinterface

`default_nettype wire

>>> hdl/hsvrgb_front.sv
// Front end of the converter: hue wrapping, sector split, chroma products and the rounded
// numerators of each colour lane, in six register stages. Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_front import hsvrgb_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      en_i,
  input  wire logic                                      valid_i,
  input  wire logic signed [HUE_W-1:0]                   hue_i,
  input  wire logic [COMPONENT_BITS-1:0]                 sat_i,
  input  wire logic [COMPONENT_BITS-1:0]                 bri_i,
  input  wire logic [COMPONENT_BITS-1:0]                 alpha_i,
  output logic                                           valid_o,
  output logic [NUM_COLOUR_LANES-1:0][2*COMPONENT_BITS+RAMP_W-1:0] num_o,
  output logic [COMPONENT_BITS-1:0]                      alpha_o
);

  localparam int unsigned W = COMPONENT_BITS;
  localparam int unsigned PW = 2 * W;
  localparam int unsigned NB = PW + RAMP_W;
  localparam int unsigned STAGES = 6;
  localparam int unsigned FULL_I = (1 << W) - 1;
  localparam logic [W-1:0] FULL = W'(FULL_I);

  localparam int unsigned HUE_TURN = 5760;
  localparam int unsigned HUE_SECTOR = 960;
  localparam int unsigned U_W = HUE_W + 1;
  localparam int unsigned HUE_OFFSET = 6 * HUE_TURN;
  localparam int unsigned RECIP_SHIFT = 26;
  localparam int unsigned RECIP_W = 17;
  localparam int unsigned RECIP = (1 << RECIP_SHIFT) / HUE_SECTOR;
  localparam int unsigned Q_W = 7;
  localparam int unsigned MOD6_MUL = 43;
  localparam int unsigned MOD6_SHIFT = 8;
  localparam int unsigned D_W = 13;
  localparam logic [NB-1:0] ROUND = NB'(FULL_I * (HUE_SECTOR / 2));

  logic [STAGES-1:0] v_q;

  logic [U_W-1:0] s1_u_d, s1_u_q;
  logic [PW-1:0]  s1_p_d, s1_p_q, s1_m_d, s1_m_q;
  logic [W-1:0]   s1_a_q;
  logic [U_W:0]   hue_sum;

  logic [U_W+RECIP_W-1:0] recip_prod;
  logic [Q_W-1:0] s2_qe_d, s2_qe_q;
  logic [U_W-1:0] s2_u_q;
  logic [PW-1:0]  s2_p_q, s2_m_q;
  logic [W-1:0]   s2_a_q;

  logic [U_W-1:0]    base, rem;
  logic              rem_big;
  logic [RAMP_W-1:0] s3_f_d, s3_f_q;
  logic [Q_W-1:0]    s3_q_d, s3_q_q;
  logic [PW-1:0]     s3_p_q, s3_m_q;
  logic [W-1:0]      s3_a_q;

  logic [D_W-1:0]    d_full;
  logic [Q_W-1:0]    six_d;
  sector_e           s4_sec_d, s4_sec_q;
  logic [RAMP_W-1:0] s4_ramp_d, s4_ramp_q;
  logic [PW-1:0]     s4_p_q, s4_m_q;
  logic [W-1:0]      s4_a_q;

  logic [NB-1:0] s5_cn_d, s5_cn_q, s5_xn_d, s5_xn_q, s5_mn_d, s5_mn_q;
  sector_e       s5_sec_q;
  logic [W-1:0]  s5_a_q;

  logic [NUM_COLOUR_LANES-1:0][NB-1:0] sel;
  logic [NUM_COLOUR_LANES-1:0][NB-1:0] s6_num_d, s6_num_q;
  logic [W-1:0] s6_a_q;

  always_comb begin
    hue_sum = {{2{hue_i[HUE_W-1]}}, hue_i} + (U_W+1)'(HUE_OFFSET);
    s1_u_d = hue_sum[U_W-1:0];
    s1_p_d = PW'(sat_i) * PW'(bri_i);
    s1_m_d = PW'(bri_i) * PW'(FULL - sat_i);
  end

  always_comb begin
    recip_prod = (U_W+RECIP_W)'(s1_u_q) * (U_W+RECIP_W)'(RECIP);
    s2_qe_d = recip_prod[RECIP_SHIFT +: Q_W];
  end

  always_comb begin
    base = U_W'(s2_qe_q) * U_W'(HUE_SECTOR);
    rem = s2_u_q - base;
    rem_big = rem >= U_W'(HUE_SECTOR);
    s3_f_d = rem_big ? RAMP_W'(rem - U_W'(HUE_SECTOR)) : RAMP_W'(rem);
    s3_q_d = s2_qe_q + Q_W'(rem_big);
  end

  always_comb begin
    d_full = D_W'(s3_q_q) * D_W'(MOD6_MUL);
    six_d = Q_W'(d_full[D_W-1:MOD6_SHIFT]) * Q_W'(6);
    s4_sec_d = sector_e'(3'(s3_q_q - six_d));
    s4_ramp_d = s3_q_q[0] ? (RAMP_W'(HUE_SECTOR) - s3_f_q) : s3_f_q;
  end

  always_comb begin
    s5_cn_d = NB'(s4_p_q) * NB'(HUE_SECTOR);
    s5_xn_d = NB'(s4_p_q) * NB'(s4_ramp_q);
    s5_mn_d = NB'(s4_m_q) * NB'(HUE_SECTOR);
  end

  always_comb begin
    case (s5_sec_q)
      SEC_RED_YELLOW: begin
        sel[LANE_R] = s5_cn_q; sel[LANE_G] = s5_xn_q; sel[LANE_B] = '0;
      end
      SEC_YELLOW_GREEN: begin
        sel[LANE_R] = s5_xn_q; sel[LANE_G] = s5_cn_q; sel[LANE_B] = '0;
      end
      SEC_GREEN_CYAN: begin
        sel[LANE_R] = '0; sel[LANE_G] = s5_cn_q; sel[LANE_B] = s5_xn_q;
      end
      SEC_CYAN_BLUE: begin
        sel[LANE_R] = '0; sel[LANE_G] = s5_xn_q; sel[LANE_B] = s5_cn_q;
      end
      SEC_BLUE_MAGENTA: begin
        sel[LANE_R] = s5_xn_q; sel[LANE_G] = '0; sel[LANE_B] = s5_cn_q;
      end
      default: begin
        sel[LANE_R] = s5_cn_q; sel[LANE_G] = '0; sel[LANE_B] = s5_xn_q;
      end
    endcase
    for (int l = 0; l < NUM_COLOUR_LANES; l++) begin
      s6_num_d[l] = sel[l] + s5_mn_q + ROUND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_u_q <= s1_u_d;
      s1_p_q <= s1_p_d;
      s1_m_q <= s1_m_d;
      s1_a_q <= alpha_i;

      s2_qe_q <= s2_qe_d;
      s2_u_q <= s1_u_q;
      s2_p_q <= s1_p_q;
      s2_m_q <= s1_m_q;
      s2_a_q <= s1_a_q;

      s3_f_q <= s3_f_d;
      s3_q_q <= s3_q_d;
      s3_p_q <= s2_p_q;
      s3_m_q <= s2_m_q;
      s3_a_q <= s2_a_q;

      s4_sec_q <= s4_sec_d;
      s4_ramp_q <= s4_ramp_d;
      s4_p_q <= s3_p_q;
      s4_m_q <= s3_m_q;
      s4_a_q <= s3_a_q;

      s5_cn_q <= s5_cn_d;
      s5_xn_q <= s5_xn_d;
      s5_mn_q <= s5_mn_d;
      s5_sec_q <= s4_sec_q;
      s5_a_q <= s4_a_q;

      s6_num_q <= s6_num_d;
      s6_a_q <= s5_a_q;
    end
  end

  assign valid_o = v_q[STAGES-1];
  assign num_o = s6_num_q;
  assign alpha_o = s6_a_q;

endmodule

`default_nettype wire

>>> hdl/hsvrgb_div.sv
// Divider of the converter: divides the rounded numerators of each colour lane by the full-scale
// sector constant by a reciprocal estimate and one correcting subtract, in two register stages,
// then clamps. Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_div import hsvrgb_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8
) (
  input  wire logic                                                clk_i,
  input  wire logic                                                rst_ni,
  input  wire logic                                                en_i,
  input  wire logic                                                valid_i,
  input  wire logic [NUM_COLOUR_LANES-1:0][2*COMPONENT_BITS+RAMP_W-1:0] num_i,
  input  wire logic [COMPONENT_BITS-1:0]                           alpha_i,
  output logic                                                     valid_o,
  output logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]                 data_o
);

  localparam int unsigned W = COMPONENT_BITS;
  localparam int unsigned NB = 2 * W + RAMP_W;
  localparam int unsigned QB = W + 1;
  localparam int unsigned STAGES = 2;
  localparam int unsigned HUE_SECTOR = 960;
  localparam longint unsigned FULL_I = (64'd1 << W) - 64'd1;
  localparam longint unsigned DIVISOR_I = FULL_I * HUE_SECTOR;
  localparam logic [W-1:0] FULL = W'(FULL_I);
  localparam logic [QB-1:0] FULL_Q = QB'(FULL_I);
  localparam logic [NB-1:0] DIVISOR = NB'(DIVISOR_I);
  localparam logic [QB-1:0] RECIP = QB'((64'd1 << NB) / DIVISOR_I);

  logic [STAGES-1:0] v_q;
  logic [NUM_COLOUR_LANES-1:0][NB+QB-1:0] prod;
  logic [NUM_COLOUR_LANES-1:0][QB-1:0] est_d, est_q;
  logic [NUM_COLOUR_LANES-1:0][NB-1:0] num_q;
  logic [NUM_COLOUR_LANES-1:0][NB-1:0] rem;
  logic [NUM_COLOUR_LANES-1:0][QB-1:0] quo_d, quo_q;
  logic [W-1:0] alp1_q, alp2_q;

  // The estimate is the true quotient or one below it, so a single compare corrects it.
  always_comb begin
    for (int l = 0; l < NUM_COLOUR_LANES; l++) begin
      prod[l] = (NB+QB)'(num_i[l]) * (NB+QB)'(RECIP);
      est_d[l] = prod[l][NB +: QB];
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_COLOUR_LANES; l++) begin
      rem[l] = num_q[l] - NB'(est_q[l]) * DIVISOR;
      quo_d[l] = est_q[l] + QB'(rem[l] >= DIVISOR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STAGES-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      est_q <= est_d;
      num_q <= num_i;
      alp1_q <= alpha_i;
      quo_q <= quo_d;
      alp2_q <= alp1_q;
    end
  end

  always_comb begin
    for (int l = 0; l < NUM_COLOUR_LANES; l++) begin
      data_o[l] = (quo_q[l] > FULL_Q) ? FULL : quo_q[l][W-1:0];
    end
    data_o[LANE_A] = alp2_q;
  end

  assign valid_o = v_q[STAGES-1];

endmodule

`default_nettype wire

>>> hdl/hsvrgb_obuf.sv
// Two-entry output buffer: an output register and a skid register, which also produce the
// advance enable of the whole pipeline. Depends on hsvrgb_pkg for the lane count.
`default_nettype none

module hsvrgb_obuf import hsvrgb_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8
) (
  input  wire logic                                        clk_i,
  input  wire logic                                        rst_ni,
  input  wire logic                                        pipe_valid_i,
  input  wire logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]    pipe_data_i,
  output logic                                             en_o,
  output logic                                             out_valid_o,
  input  wire logic                                        out_ready_i,
  output logic [NUM_LANES-1:0][COMPONENT_BITS-1:0]         out_data_o
);

  logic out_v_d, out_v_q, skid_v_d, skid_v_q;
  logic [NUM_LANES-1:0][COMPONENT_BITS-1:0] out_data_d, out_data_q, skid_data_d, skid_data_q;
  logic take, push;

  assign en_o = !skid_v_q;
  assign take = out_v_q && out_ready_i;
  assign push = en_o && pipe_valid_i;

  always_comb begin
    out_v_d = out_v_q;
    out_data_d = out_data_q;
    skid_v_d = skid_v_q;
    skid_data_d = skid_data_q;
    if (take || !out_v_q) begin
      if (skid_v_q) begin
        out_v_d = 1'b1;
        out_data_d = skid_data_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = push;
        out_data_d = pipe_data_i;
      end
    end else if (push) begin
      skid_v_d = 1'b1;
      skid_data_d = pipe_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("Skid register holds a transaction while the output register is empty.");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i && push) |=> skid_v_q)
    else $error("A transaction arriving at a stalled output was not kept in the skid register.");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && out_ready_i) |=> (!skid_v_q && out_v_q))
    else $error("Skid register did not move into the output register once it was taken.");

endmodule

`default_nettype wire

>>> hdl/hsv_to_rgb_converter.sv
// Channel   Role    Handshake     Payload
// hsva_i    sink    valid/ready   hue (signed 1/16 degree), saturation, brightness, alpha_in
// rgba_o    source  valid/ready   red, green, blue, alpha_out
//
// One transaction is taken per clock while the pipeline is not frozen; the result passes
// through six front stages, two divider stages (a reciprocal estimate, then one correcting
// subtract) and the output register.
// Reset clears only the valid flags; the data path holds no state between transactions.
// A stalled output is absorbed by a skid register; the pipeline freezes only when both the
// output and skid registers are full, and nothing is lost or repeated.
// Top level of the HSV to RGB converter. Depends on hsvrgb_pkg, both interfaces,
// hsvrgb_front, hsvrgb_div and hsvrgb_obuf.
`default_nettype none

module hsv_to_rgb_converter import hsvrgb_pkg::*; #(
  parameter int unsigned COMPONENT_BITS = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  hsvrgb_hsva_if.sink    hsva_i,
  hsvrgb_rgba_if.source  rgba_o
);

  localparam int unsigned NB = 2 * COMPONENT_BITS + RAMP_W;

  logic en;
  logic front_valid, div_valid;
  logic [NUM_COLOUR_LANES-1:0][NB-1:0] front_num;
  logic [COMPONENT_BITS-1:0] front_alpha;
  logic [NUM_LANES-1:0][COMPONENT_BITS-1:0] div_data, out_data;

  hsvrgb_front #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (hsva_i.valid),
    .hue_i   (hsva_i.hue),
    .sat_i   (hsva_i.saturation),
    .bri_i   (hsva_i.brightness),
    .alpha_i (hsva_i.alpha_in),
    .valid_o (front_valid),
    .num_o   (front_num),
    .alpha_o (front_alpha)
  );

  hsvrgb_div #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (front_valid),
    .num_i   (front_num),
    .alpha_i (front_alpha),
    .valid_o (div_valid),
    .data_o  (div_data)
  );

  hsvrgb_obuf #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pipe_valid_i (div_valid),
    .pipe_data_i  (div_data),
    .en_o         (en),
    .out_valid_o  (rgba_o.valid),
    .out_ready_i  (rgba_o.ready),
    .out_data_o   (out_data)
  );

  assign hsva_i.ready = en;
  assign rgba_o.red = out_data[LANE_R];
  assign rgba_o.green = out_data[LANE_G];
  assign rgba_o.blue = out_data[LANE_B];
  assign rgba_o.alpha_out = out_data[LANE_A];

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for hsv_to_rgb_converter: drives HSVA colours and checks every RGBA
// result against a built-in integer model of the conversion, under varying flow control.
// Depends on hsvrgb_pkg, hsvrgb_hsva_if, hsvrgb_rgba_if and the converter RTL.
`default_nettype none

module tb_top import hsvrgb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COMPONENT_BITS = 8;
  localparam longint unsigned FULL = (longint'(1) << COMPONENT_BITS) - 1;
  localparam int HUE_TURN = 5760;
  localparam int HUE_SECTOR = 960;
  localparam int HUE_PAIR = 1920;
  localparam longint unsigned DEN = FULL * HUE_SECTOR;
  localparam int LATENCY = 8;
  localparam int RANDOM_PER_PHASE = 325;
  localparam longint CYCLE_LIMIT = 200000;

  typedef logic [COMPONENT_BITS-1:0] comp_t;

  typedef struct packed {
    logic signed [HUE_W-1:0] hue;
    comp_t saturation;
    comp_t brightness;
    comp_t alpha;
  } hsva_t;

  typedef struct packed {
    comp_t red;
    comp_t green;
    comp_t blue;
    comp_t alpha;
  } rgba_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsvrgb_hsva_if #(.COMPONENT_BITS(COMPONENT_BITS)) hsva ();
  hsvrgb_rgba_if #(.COMPONENT_BITS(COMPONENT_BITS)) rgba ();

  hsv_to_rgb_converter #(.COMPONENT_BITS(COMPONENT_BITS)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsva_i (hsva),
    .rgba_o (rgba)
  );

  hsva_t colour_q[$];
  rgba_t pending_rgba[$];
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned mismatches = 0;
  longint cycles = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic comp_t round_component(longint unsigned num);
    longint unsigned q;
    q = (num + DEN / 2) / DEN;
    if (q > FULL) begin
      q = FULL;
    end
    return comp_t'(q);
  endfunction

  function automatic rgba_t convert_hsva(hsva_t c);
    int wrapped;
    int ramp_off;
    longint unsigned ramp;
    longint unsigned chroma;
    longint unsigned side;
    longint unsigned floor_lvl;
    longint unsigned r_num;
    longint unsigned g_num;
    longint unsigned b_num;
    sector_e sec;
    rgba_t res;
    wrapped = int'(c.hue) % HUE_TURN;
    if (wrapped < 0) begin
      wrapped += HUE_TURN;
    end
    ramp_off = (wrapped % HUE_PAIR) - HUE_SECTOR;
    if (ramp_off < 0) begin
      ramp_off = -ramp_off;
    end
    ramp = longint'(HUE_SECTOR - ramp_off);
    chroma = longint'(c.saturation) * longint'(c.brightness) * HUE_SECTOR;
    side = longint'(c.saturation) * longint'(c.brightness) * ramp;
    floor_lvl = longint'(c.brightness) * (FULL - longint'(c.saturation)) * HUE_SECTOR;
    sec = sector_e'(wrapped / HUE_SECTOR);
    case (sec)
      SEC_RED_YELLOW: begin
        r_num = chroma; g_num = side; b_num = 0;
      end
      SEC_YELLOW_GREEN: begin
        r_num = side; g_num = chroma; b_num = 0;
      end
      SEC_GREEN_CYAN: begin
        r_num = 0; g_num = chroma; b_num = side;
      end
      SEC_CYAN_BLUE: begin
        r_num = 0; g_num = side; b_num = chroma;
      end
      SEC_BLUE_MAGENTA: begin
        r_num = side; g_num = 0; b_num = chroma;
      end
      default: begin
        r_num = chroma; g_num = 0; b_num = side;
      end
    endcase
    res.red = round_component(r_num + floor_lvl);
    res.green = round_component(g_num + floor_lvl);
    res.blue = round_component(b_num + floor_lvl);
    res.alpha = c.alpha;
    return res;
  endfunction

  function automatic comp_t random_level();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) begin
      return '0;
    end else if (pick == 1) begin
      return comp_t'(FULL);
    end
    return comp_t'($urandom);
  endfunction

  function automatic hsva_t random_colour();
    hsva_t c;
    int h;
    case ($urandom_range(0, 3))
      0, 1: begin
        h = int'($urandom_range(0, 65535));
      end
      2: begin
        // Land on or next to a sector boundary, a few turns either side of zero.
        h = (int'($urandom_range(0, 9)) - 5) * HUE_TURN
            + int'($urandom_range(0, 5)) * HUE_SECTOR + int'($urandom_range(0, 4)) - 2;
      end
      default: begin
        h = int'($urandom_range(0, 11519)) - HUE_TURN;
      end
    endcase
    c.hue = h[HUE_W-1:0];
    c.saturation = random_level();
    c.brightness = random_level();
    c.alpha = comp_t'($urandom);
    return c;
  endfunction

  task automatic add_colour(int h, longint s, longint v, longint a);
    hsva_t c;
    c.hue = h[HUE_W-1:0];
    c.saturation = comp_t'(s);
    c.brightness = comp_t'(v);
    c.alpha = comp_t'(a);
    colour_q = {colour_q, c};
  endtask

  task automatic wait_drained();
    while (colour_q.size() != 0 || hsva.valid || pending_rgba.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic run_phase(int unsigned src_pct, int unsigned snk_pct, int unsigned count);
    wait_drained();
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (count) begin
      colour_q = {colour_q, random_colour()};
    end
  endtask

  task automatic check_lane(string name, comp_t want, comp_t got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    hsva_t nxt;
    if (rst_ni) begin
      if (hsva.valid && hsva.ready) begin
        nxt.hue = hsva.hue;
        nxt.saturation = hsva.saturation;
        nxt.brightness = hsva.brightness;
        nxt.alpha = hsva.alpha_in;
        pending_rgba = {pending_rgba, convert_hsva(nxt)};
      end
      if (!hsva.valid || hsva.ready) begin
        if (colour_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          nxt = colour_q.pop_front();
          hsva.valid <= 1'b1;
          hsva.hue <= nxt.hue;
          hsva.saturation <= nxt.saturation;
          hsva.brightness <= nxt.brightness;
          hsva.alpha_in <= nxt.alpha;
        end else begin
          hsva.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    rgba_t want;
    if (rst_ni) begin
      if (rgba.valid && rgba.ready) begin
        if (pending_rgba.size() == 0) begin
          $error("unexpected transaction: red %0d green %0d blue %0d alpha %0d",
                 rgba.red, rgba.green, rgba.blue, rgba.alpha_out);
          mismatches++;
        end else begin
          want = pending_rgba.pop_front();
          check_lane("red", want.red, rgba.red);
          check_lane("green", want.green, rgba.green);
          check_lane("blue", want.blue, rgba.blue);
          check_lane("alpha_out", want.alpha, rgba.alpha_out);
        end
      end
      rgba.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    hsva.valid = 1'b0;
    hsva.hue = '0;
    hsva.saturation = '0;
    hsva.brightness = '0;
    hsva.alpha_in = '0;
    rgba.ready = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Extremes of every field, each sector start and the wrap of negative hues.
    add_colour(0, FULL, FULL, FULL);
    add_colour(960, FULL, FULL, 0);
    add_colour(1920, FULL, FULL, 85);
    add_colour(2880, FULL, FULL, 170);
    add_colour(3840, FULL, FULL, FULL);
    add_colour(4800, FULL, FULL, 0);
    add_colour(959, FULL, FULL, 1);
    add_colour(5759, FULL, FULL, 2);
    add_colour(5760, FULL, FULL, 3);
    add_colour(-1, FULL, FULL, 4);
    add_colour(-960, FULL, FULL, 5);
    add_colour(-5760, FULL, FULL, 6);
    add_colour(-32768, FULL, FULL, FULL);
    add_colour(32767, FULL, FULL, 0);
    add_colour(480, FULL, FULL, 128);
    add_colour(1440, 128, 200, 127);
    add_colour(3000, 0, FULL, 255);
    add_colour(4000, FULL, 0, 0);
    add_colour(2000, 0, 0, 85);
    add_colour(-21555, 170, 85, 170);
    add_colour(21845, 85, 170, 85);
    add_colour(12345, 1, 254, 254);
    add_colour(-12345, 254, 1, 1);

    run_phase(0, 0, RANDOM_PER_PHASE);
    run_phase(85, 0, RANDOM_PER_PHASE);
    run_phase(0, 85, RANDOM_PER_PHASE);
    run_phase(32, 32, RANDOM_PER_PHASE);
    wait_drained();
    snk_stall_pct = 0;
    repeat (LATENCY + 8) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> hsv_to_rgb_converter.f
hdl/hsvrgb_pkg.sv
hdl/hsvrgb_hsva_if.sv
hdl/hsvrgb_rgba_if.sv
hdl/hsvrgb_front.sv
hdl/hsvrgb_div.sv
hdl/hsvrgb_obuf.sv
hdl/hsv_to_rgb_converter.sv
test/tb_top.sv
